// File: rtl/nsr_pkg.sv
// Node session registry: shared types, field widths, codes and constants.
// No dependencies; imported by nsr_front, nsr_back and node_session_registry_core.
package nsr_pkg;

  localparam int NODE_SLOTS_DEFAULT = 20;
  localparam int FRAMES_PER_ITEM    = 3;

  localparam int KIND_W    = 3;
  localparam int ADDR_W    = 48;
  localparam int TIME_W    = 64;
  localparam int FC_W      = 2;
  localparam int CTR_W     = 16;
  localparam int OUTC_W    = 4;
  localparam int SLOT_W    = 5;
  localparam int DISC_W    = 5;
  localparam int TIMEOUT_W = 40;
  localparam int STATUS_W  = 2;
  localparam int PADDR_W   = 4;
  localparam int PDATA_W   = 64;

  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = TIMEOUT_W'(300000000);

  // counters that can ever be valid in one data item
  localparam logic [FC_W-1:0] FRAME_CAP = (FRAMES_PER_ITEM < 3) ? FC_W'(FRAMES_PER_ITEM) :
                                                                  FC_W'(3);

  // register select bit of paddr
  localparam logic REG_TIMEOUT = 1'b0;
  localparam logic REG_SYNC    = 1'b1;

  localparam logic [KIND_W-1:0] KIND_REGISTER = 3'd0;
  localparam logic [KIND_W-1:0] KIND_DATA     = 3'd1;
  localparam logic [KIND_W-1:0] KIND_TICK     = 3'd2;
  localparam logic [KIND_W-1:0] KIND_LOOKUP   = 3'd3;

  localparam logic [2:0] OP_REG    = 3'd0;
  localparam logic [2:0] OP_DATA   = 3'd1;
  localparam logic [2:0] OP_TICK   = 3'd2;
  localparam logic [2:0] OP_LOOKUP = 3'd3;
  localparam logic [2:0] OP_BAD    = 3'd4;

  localparam logic [OUTC_W-1:0] OUT_NEW         = 4'd0;
  localparam logic [OUTC_W-1:0] OUT_RECONNECTED = 4'd1;
  localparam logic [OUTC_W-1:0] OUT_FULL        = 4'd2;
  localparam logic [OUTC_W-1:0] OUT_ACKED       = 4'd3;
  localparam logic [OUTC_W-1:0] OUT_UNKNOWN     = 4'd4;
  localparam logic [OUTC_W-1:0] OUT_SWEEP       = 4'd5;
  localparam logic [OUTC_W-1:0] OUT_FOUND       = 4'd6;
  localparam logic [OUTC_W-1:0] OUT_NOT_FOUND   = 4'd7;
  localparam logic [OUTC_W-1:0] OUT_BAD         = 4'd8;

  localparam logic [STATUS_W-1:0] ST_STREAMING    = 2'd1;
  localparam logic [STATUS_W-1:0] ST_DISCONNECTED = 2'd2;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [ADDR_W-1:0] node_addr;
    logic [TIME_W-1:0] now_us;
    logic [FC_W-1:0]   valid_frames;
    logic [CTR_W-1:0]  counter_a;
    logic [CTR_W-1:0]  counter_b;
    logic [CTR_W-1:0]  counter_c;
  } in_t;

  typedef struct packed {
    logic [OUTC_W-1:0] outcome;
    logic              send_welcome;
    logic [CTR_W-1:0]  floor_value;
    logic [SLOT_W-1:0] slot;
    logic [DISC_W-1:0] disconnected_count;
  } res_t;

  typedef struct packed {
    logic [2:0]        op;
    logic [ADDR_W-1:0] addr;
    logic [TIME_W-1:0] now;
    logic [CTR_W-1:0]  cmax;
  } cmd_t;

  typedef struct packed {
    logic [TIMEOUT_W-1:0] timeout;
    logic                 sync_done;
  } cfg_t;

endpackage

// File: rtl/nsr_fifo.sv
// Small first-in first-out queue for any packed payload type.
// Uses no package; instantiated twice by node_session_registry_core.
module nsr_fifo #(
  parameter type T     = logic,
  parameter int  DEPTH = 2
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  T     wdata,
  output logic full,
  input  logic pop,
  output T     rdata,
  output logic empty
);
  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [NW-1:0] DEPTH_C  = NW'(DEPTH);

  T                mem [DEPTH];
  logic [PW-1:0]   wptr;
  logic [PW-1:0]   rptr;
  logic [NW-1:0]   count;
  logic            do_push;
  logic            do_pop;

  assign full    = (count == DEPTH_C);
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wptr <= (wptr == LAST_PTR) ? '0 : wptr + PW'(1);
      end
      if (do_pop) begin
        rptr <= (rptr == LAST_PTR) ? '0 : rptr + PW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + NW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - NW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wptr] <= wdata;
    end
  end

endmodule

// File: rtl/nsr_front.sv
// Front end: takes input items, decodes the kind and reduces the frame counters.
// Depends on nsr_pkg; feeds the command queue in node_session_registry_core.
module nsr_front (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  nsr_pkg::in_t item,
  output logic         full,
  output logic         cmd_valid,
  output nsr_pkg::cmd_t cmd,
  input  logic         cmd_full
);
  import nsr_pkg::*;

  logic            hold_v;
  cmd_t            hold;
  cmd_t            cls;
  logic            accept;
  logic            fwd;
  logic [FC_W-1:0] nval;

  assign full      = hold_v && cmd_full;
  assign accept    = push && !full;
  assign fwd       = hold_v && !cmd_full;
  assign cmd_valid = hold_v;
  assign cmd       = hold;

  always_comb begin
    nval = (item.valid_frames > FRAME_CAP) ? FRAME_CAP : item.valid_frames;
    cls.addr = item.node_addr;
    cls.now  = item.now_us;
    cls.cmax = '0;
    if (nval >= FC_W'(1)) begin
      cls.cmax = item.counter_a;
    end
    if (nval >= FC_W'(2) && item.counter_b > cls.cmax) begin
      cls.cmax = item.counter_b;
    end
    if (nval >= FC_W'(3) && item.counter_c > cls.cmax) begin
      cls.cmax = item.counter_c;
    end
    unique case (item.kind)
      KIND_REGISTER: cls.op = OP_REG;
      KIND_DATA:     cls.op = OP_DATA;
      KIND_TICK:     cls.op = OP_TICK;
      KIND_LOOKUP:   cls.op = OP_LOOKUP;
      default:       cls.op = OP_BAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_v <= 1'b0;
    end else begin
      hold_v <= accept || (hold_v && !fwd);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      hold <= cls;
    end
  end

endmodule

// File: rtl/nsr_back.sv
// Back end: session table memories and the sequencer that scans them per command.
// Depends on nsr_pkg; reads the command queue and writes the result queue.
module nsr_back #(
  parameter int NODE_SLOTS = nsr_pkg::NODE_SLOTS_DEFAULT
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          cmd_valid,
  input  nsr_pkg::cmd_t cmd,
  output logic          cmd_pop,
  input  nsr_pkg::cfg_t cfg,
  input  logic          res_full,
  output logic          res_push,
  output nsr_pkg::res_t res
);
  import nsr_pkg::*;

  localparam int IW = (NODE_SLOTS > 1) ? $clog2(NODE_SLOTS) : 1;
  localparam int CW = $clog2(NODE_SLOTS + 1);
  localparam logic [CW-1:0] SLOTS_C = CW'(NODE_SLOTS);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_MISS = 2'd2;

  logic [ADDR_W-1:0]   addr_mem   [NODE_SLOTS];
  logic [CTR_W-1:0]    floor_mem  [NODE_SLOTS];
  logic [TIME_W-1:0]   seen_mem   [NODE_SLOTS];
  logic [STATUS_W-1:0] status_mem [NODE_SLOTS];

  logic [1:0]          state;
  cmd_t                cur;
  logic [CW-1:0]       node_count;
  logic [CW-1:0]       ridx;
  logic                rd_v;
  logic [IW-1:0]       cidx;
  logic [CW-1:0]       disc;
  logic [ADDR_W-1:0]   addr_q;
  logic [CTR_W-1:0]    floor_q;
  logic [TIME_W-1:0]   seen_q;
  logic [STATUS_W-1:0] status_q;

  logic                start;
  logic                issue;
  logic                last;
  logic                hit;
  logic                expire;
  logic                is_full;
  logic [TIME_W:0]     age;
  logic [CTR_W-1:0]    new_floor;
  logic [IW-1:0]       wa;
  logic                we_addr;
  logic                we_floor;
  logic                we_seen;
  logic                we_status;
  logic [CTR_W-1:0]    floor_d;
  logic [STATUS_W-1:0] status_d;

  assign start     = (state == S_IDLE) && cmd_valid && !res_full;
  assign cmd_pop   = start;
  assign issue     = (state == S_SCAN) && (ridx < node_count);
  assign last      = rd_v && (CW'(cidx) == node_count - CW'(1));
  assign hit       = (state == S_SCAN) && rd_v && (cur.op != OP_TICK) && (addr_q == cur.addr);
  assign age       = {1'b0, cur.now} - {1'b0, seen_q};
  assign expire    = (state == S_SCAN) && rd_v && (cur.op == OP_TICK) &&
                     (status_q == ST_STREAMING) && !age[TIME_W] &&
                     (age[TIME_W-1:0] > TIME_W'(cfg.timeout));
  assign is_full   = (node_count >= SLOTS_C);
  assign new_floor = (cur.cmax > floor_q) ? cur.cmax : floor_q;

  always_comb begin
    res       = '0;
    res_push  = 1'b0;
    wa        = cidx;
    we_addr   = 1'b0;
    we_floor  = 1'b0;
    we_seen   = 1'b0;
    we_status = 1'b0;
    floor_d   = '0;
    status_d  = ST_STREAMING;
    unique case (state)
      S_SCAN: begin
        if (expire) begin
          we_status = 1'b1;
          status_d  = ST_DISCONNECTED;
        end
        if (hit) begin
          res_push = 1'b1;
          res.slot = SLOT_W'(cidx);
          priority case (cur.op)
            OP_REG: begin
              res.outcome      = OUT_RECONNECTED;
              res.send_welcome = cfg.sync_done;
              we_floor         = 1'b1;
              we_seen          = 1'b1;
              we_status        = 1'b1;
            end
            OP_DATA: begin
              res.outcome     = OUT_ACKED;
              res.floor_value = new_floor;
              floor_d         = new_floor;
              we_floor        = 1'b1;
              we_seen         = 1'b1;
              we_status       = 1'b1;
            end
            default: res.outcome = OUT_FOUND;
          endcase
        end
      end
      S_MISS: begin
        res_push = 1'b1;
        wa       = node_count[IW-1:0];
        unique case (cur.op)
          OP_TICK: begin
            res.outcome            = OUT_SWEEP;
            res.disconnected_count = DISC_W'(disc);
          end
          OP_LOOKUP: res.outcome = OUT_NOT_FOUND;
          OP_DATA:   res.outcome = OUT_UNKNOWN;
          OP_REG: begin
            if (is_full) begin
              res.outcome = OUT_FULL;
            end else begin
              res.outcome      = OUT_NEW;
              res.slot         = SLOT_W'(node_count);
              res.send_welcome = cfg.sync_done;
              we_addr          = 1'b1;
              we_floor         = 1'b1;
              we_seen          = 1'b1;
              we_status        = 1'b1;
            end
          end
          default: res.outcome = OUT_BAD;
        endcase
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      node_count <= '0;
      rd_v       <= 1'b0;
      ridx       <= '0;
      disc       <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (start) begin
            ridx  <= '0;
            rd_v  <= 1'b0;
            disc  <= '0;
            state <= (cmd.op == OP_BAD || node_count == '0) ? S_MISS : S_SCAN;
          end
        end
        S_SCAN: begin
          if (issue) begin
            ridx <= ridx + CW'(1);
          end
          rd_v <= issue;
          if (expire) begin
            disc <= disc + CW'(1);
          end
          if (hit) begin
            state <= S_IDLE;
          end else if (last) begin
            state <= S_MISS;
          end
        end
        S_MISS: begin
          state <= S_IDLE;
          if (cur.op == OP_REG && !is_full) begin
            node_count <= node_count + CW'(1);
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      cur <= cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (we_addr) begin
      addr_mem[wa] <= cur.addr;
    end
    if (we_floor) begin
      floor_mem[wa] <= floor_d;
    end
    if (we_seen) begin
      seen_mem[wa] <= cur.now;
    end
    if (we_status) begin
      status_mem[wa] <= status_d;
    end
    if (issue) begin
      addr_q   <= addr_mem[ridx[IW-1:0]];
      floor_q  <= floor_mem[ridx[IW-1:0]];
      seen_q   <= seen_mem[ridx[IW-1:0]];
      status_q <= status_mem[ridx[IW-1:0]];
      cidx     <= ridx[IW-1:0];
    end
  end

endmodule

// File: rtl/node_session_registry_core.sv
// Node session registry top level: config registers, front end, queues, back end.
// Depends on nsr_pkg, nsr_front, nsr_fifo and nsr_back.
//
//   channel   handshake             payload
//   input     push / full           item   (nsr_pkg::in_t)
//   result    pop / empty           result (nsr_pkg::res_t)
//   config    psel penable pwrite   paddr[3] selects timeout_us or sync_done, pwdata, prdata
//
// One request at a time in the back end. A command scans the table one slot per
// cycle through the registered read of the slot memories: a hit ends the scan,
// a miss or a tick reads every slot before the miss state, and a bad kind or
// an empty table goes straight to the miss state. The front end holds each command
// in a register ahead of the command queue; the two-entry queues absorb stalls;
// a full result queue holds the next command in the command queue.
// Reset clears control state and the node count; table contents stay as they are.
module node_session_registry_core #(
  parameter int NODE_SLOTS = nsr_pkg::NODE_SLOTS_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [nsr_pkg::PADDR_W-1:0]   paddr,
  input  logic [nsr_pkg::PDATA_W-1:0]   pwdata,
  output logic [nsr_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready,
  input  logic                          push,
  input  nsr_pkg::in_t                  item,
  output logic                          full,
  output logic                          empty,
  input  logic                          pop,
  output nsr_pkg::res_t                 result
);
  import nsr_pkg::*;

  cfg_t cfg;
  logic cfg_we;
  logic front_valid;
  cmd_t front_cmd;
  logic cq_full;
  logic cq_empty;
  cmd_t cq_cmd;
  logic cq_pop;
  logic rq_full;
  logic res_push;
  res_t res;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;

  always_comb begin
    unique case (paddr[3])
      REG_SYNC: prdata = PDATA_W'(cfg.sync_done);
      default:  prdata = PDATA_W'(cfg.timeout);
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.timeout   <= TIMEOUT_RESET;
      cfg.sync_done <= 1'b0;
    end else if (cfg_we) begin
      unique case (paddr[3])
        REG_SYNC: cfg.sync_done <= pwdata[0];
        default:  cfg.timeout   <= pwdata[TIMEOUT_W-1:0];
      endcase
    end
  end

  nsr_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .item      (item),
    .full      (full),
    .cmd_valid (front_valid),
    .cmd       (front_cmd),
    .cmd_full  (cq_full)
  );

  nsr_fifo #(
    .T     (cmd_t),
    .DEPTH (2)
  ) u_cmd_q (
    .clk   (clk),
    .rst   (rst),
    .push  (front_valid),
    .wdata (front_cmd),
    .full  (cq_full),
    .pop   (cq_pop),
    .rdata (cq_cmd),
    .empty (cq_empty)
  );

  nsr_back #(
    .NODE_SLOTS (NODE_SLOTS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (!cq_empty),
    .cmd       (cq_cmd),
    .cmd_pop   (cq_pop),
    .cfg       (cfg),
    .res_full  (rq_full),
    .res_push  (res_push),
    .res       (res)
  );

  nsr_fifo #(
    .T     (res_t),
    .DEPTH (2)
  ) u_res_q (
    .clk   (clk),
    .rst   (rst),
    .push  (res_push),
    .wdata (res),
    .full  (rq_full),
    .pop   (pop),
    .rdata (result),
    .empty (empty)
  );

endmodule

// File: tb/testbench.sv
// Self-checking testbench for node_session_registry_core: queue-style request and
// result ports, APB-style register port. Depends on nsr_pkg and the RTL of the block.
// A predictor built from the registry's rules checks every result field by field.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import nsr_pkg::*;

  localparam int SLOTS       = NODE_SLOTS_DEFAULT;
  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 400;
  localparam int PHASE_ITEMS = 120;

  localparam logic [KIND_W-1:0]  KIND_BAD_FIRST = 3'd4;
  localparam logic [KIND_W-1:0]  KIND_BAD_LAST  = 3'd7;
  localparam logic [PADDR_W-1:0] TIMEOUT_ADDR   = {REG_TIMEOUT, 3'b000};
  localparam logic [PADDR_W-1:0] SYNC_ADDR      = {REG_SYNC, 3'b000};

  logic               clk     = 1'b0;
  logic               rst     = 1'b1;
  logic               psel    = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite  = 1'b0;
  logic [PADDR_W-1:0] paddr   = '0;
  logic [PDATA_W-1:0] pwdata  = '0;
  logic [PDATA_W-1:0] prdata;
  logic               pready;
  logic               push    = 1'b0;
  in_t                item    = '0;
  logic               full;
  logic               empty;
  logic               pop     = 1'b0;
  res_t               result;

  node_session_registry_core #(.NODE_SLOTS(SLOTS)) dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .push(push), .item(item), .full(full),
    .empty(empty), .pop(pop), .result(result)
  );

  always #6 clk = ~clk;

  // predictor state and register copies
  logic [ADDR_W-1:0]    node_addrs [SLOTS];
  logic [CTR_W-1:0]     node_floors[SLOTS];
  logic [TIME_W-1:0]    node_seen  [SLOTS];
  logic [STATUS_W-1:0]  node_state [SLOTS];
  int                   nodes_used = 0;
  logic [TIMEOUT_W-1:0] cfg_timeout = TIMEOUT_RESET;
  logic                 cfg_sync    = 1'b0;

  in_t               pending_items[$];
  res_t              expected_results[$];
  logic [ADDR_W-1:0] reg_pool[$];
  logic [TIME_W-1:0] now_clock = '0;

  int items_queued     = 0;
  int items_accepted   = 0;
  int results_seen     = 0;
  int errors           = 0;
  int settings_written = 0;
  int disc_total       = 0;
  int outcome_hits[16];
  int cycle_count      = 0;
  int send_gap         = 0;
  int drain_gap        = 0;
  int hold_left        = 0;
  bit hold_done        = 0;

  function automatic res_t registry_step(input in_t req);
    res_t             r;
    int               hit;
    int               valid;
    int               disc;
    logic [CTR_W-1:0] ctr[3];
    r = '0;
    r.outcome = OUT_BAD;
    hit = -1;
    disc = 0;
    ctr[0] = req.counter_a;
    ctr[1] = req.counter_b;
    ctr[2] = req.counter_c;
    for (int i = 0; i < nodes_used; i++)
      if (hit < 0 && node_addrs[i] == req.node_addr) hit = i;
    case (req.kind)
      KIND_REGISTER: begin
        if (hit < 0 && nodes_used >= SLOTS) begin
          r.outcome = OUT_FULL;
        end else begin
          if (hit >= 0) begin
            r.outcome = OUT_RECONNECTED;
          end else begin
            hit = nodes_used;
            nodes_used++;
            node_addrs[hit] = req.node_addr;
            r.outcome = OUT_NEW;
          end
          node_floors[hit] = '0;
          node_seen[hit] = req.now_us;
          node_state[hit] = ST_STREAMING;
          r.slot = SLOT_W'(hit);
          r.send_welcome = cfg_sync;
        end
      end
      KIND_DATA: begin
        if (hit < 0) begin
          r.outcome = OUT_UNKNOWN;
        end else begin
          valid = req.valid_frames;
          if (valid > FRAMES_PER_ITEM) valid = FRAMES_PER_ITEM;
          if (valid > 3) valid = 3;
          node_seen[hit] = req.now_us;
          node_state[hit] = ST_STREAMING;
          for (int k = 0; k < valid; k++)
            if (ctr[k] > node_floors[hit]) node_floors[hit] = ctr[k];
          r.outcome = OUT_ACKED;
          r.floor_value = node_floors[hit];
          r.slot = SLOT_W'(hit);
        end
      end
      KIND_TICK: begin
        for (int i = 0; i < nodes_used; i++) begin
          if (node_state[i] == ST_STREAMING && req.now_us >= node_seen[i] &&
              req.now_us - node_seen[i] > TIME_W'(cfg_timeout)) begin
            node_state[i] = ST_DISCONNECTED;
            disc++;
          end
        end
        r.outcome = OUT_SWEEP;
        r.disconnected_count = DISC_W'(disc);
      end
      KIND_LOOKUP: begin
        if (hit < 0) begin
          r.outcome = OUT_NOT_FOUND;
        end else begin
          r.outcome = OUT_FOUND;
          r.slot = SLOT_W'(hit);
        end
      end
      default: r.outcome = OUT_BAD;
    endcase
    return r;
  endfunction

  // every fourth stretch of 64 handshakes runs without gaps
  function automatic int pick_gap(input int count);
    int r;
    r = $urandom_range(0, 99);
    if ((count / 64) % 4 == 3) return 0;
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic add_item(input logic [KIND_W-1:0] kind, input logic [ADDR_W-1:0] addr,
                          input logic [TIME_W-1:0] now, input logic [FC_W-1:0] fc,
                          input logic [CTR_W-1:0] a, input logic [CTR_W-1:0] b,
                          input logic [CTR_W-1:0] c);
    in_t req;
    req.kind = kind;
    req.node_addr = addr;
    req.now_us = now;
    req.valid_frames = fc;
    req.counter_a = a;
    req.counter_b = b;
    req.counter_c = c;
    pending_items.push_back(req);
    items_queued++;
  endtask

  task automatic apb_access(input logic wr, input logic [PADDR_W-1:0] a,
                            input logic [PDATA_W-1:0] d, output logic [PDATA_W-1:0] q);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= a;
    pwdata <= d;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    q = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic check_config();
    logic [PDATA_W-1:0] q;
    apb_access(1'b0, TIMEOUT_ADDR, '0, q);
    if (q !== PDATA_W'(cfg_timeout)) begin
      $error("timeout_us: expected %0d, actual %0d", cfg_timeout, q);
      errors++;
    end
    apb_access(1'b0, SYNC_ADDR, '0, q);
    if (q !== PDATA_W'(cfg_sync)) begin
      $error("sync_done: expected %0d, actual %0d", cfg_sync, q);
      errors++;
    end
  endtask

  task automatic set_config(input logic [TIMEOUT_W-1:0] timeout, input logic sync);
    logic [PDATA_W-1:0] q;
    apb_access(1'b1, TIMEOUT_ADDR, PDATA_W'(timeout), q);
    apb_access(1'b1, SYNC_ADDR, PDATA_W'(sync), q);
    cfg_timeout = timeout;
    cfg_sync = sync;
    settings_written++;
    check_config();
  endtask

  task automatic wait_idle();
    while (items_accepted != items_queued || expected_results.size() != 0)
      @(posedge clk);
  endtask

  // mostly well-formed traffic to registered nodes, some strangers and bad kinds
  task automatic gen_phase(input int count);
    logic [KIND_W-1:0] kind;
    logic [ADDR_W-1:0] addr;
    logic [TIME_W-1:0] now;
    logic [CTR_W-1:0]  ctr[3];
    int                r;
    int                live;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(0, 99);
      if (r < 70) now_clock += $urandom_range(0, 500);
      else if (r < 90) now_clock += $urandom_range(500, 5000);
      else if (r < 97) now_clock += $urandom();
      else now_clock = {$urandom(), $urandom()};
      now = now_clock;
      if ($urandom_range(0, 99) < 3) now = now_clock - $urandom_range(1, 3000);
      for (int k = 0; k < 3; k++)
        ctr[k] = ($urandom_range(0, 3) == 0) ? CTR_W'($urandom_range(0, 255)) :
                                                CTR_W'($urandom());
      live = (reg_pool.size() < SLOTS) ? reg_pool.size() : SLOTS;
      if (live > 0 && $urandom_range(0, 99) < 85)
        addr = reg_pool[$urandom_range(0, live - 1)];
      else
        addr = ADDR_W'({$urandom(), $urandom()});
      r = $urandom_range(0, 99);
      if (r < 22) begin
        kind = KIND_REGISTER;
        if (live == 0 || $urandom_range(0, 99) < 22) begin
          addr = ADDR_W'({$urandom(), $urandom()});
          reg_pool.push_back(addr);
        end
      end else if (r < 62) kind = KIND_DATA;
      else if (r < 77) kind = KIND_TICK;
      else if (r < 93) kind = KIND_LOOKUP;
      else kind = KIND_W'($urandom_range(KIND_BAD_FIRST, KIND_BAD_LAST));
      add_item(kind, addr, now, FC_W'($urandom_range(0, 3)), ctr[0], ctr[1], ctr[2]);
    end
  endtask

  // request driver
  always @(posedge clk) begin
    if (rst) begin
      push <= 1'b0;
    end else begin
      if (push && !full) begin
        expected_results.push_back(registry_step(item));
        items_accepted++;
      end
      if (push && full) begin
        push <= 1'b1;
      end else if (send_gap > 0) begin
        send_gap--;
        push <= 1'b0;
      end else if (pending_items.size() != 0) begin
        item <= pending_items.pop_front();
        push <= 1'b1;
        send_gap = pick_gap(items_accepted);
      end else begin
        push <= 1'b0;
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    res_t exp;
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (expected_results.size() == 0) begin
          $error("unexpected result: outcome %0d slot %0d", result.outcome, result.slot);
          errors++;
        end else begin
          exp = expected_results.pop_front();
          if (result.outcome !== exp.outcome) begin
            $error("outcome: expected %0d, actual %0d", exp.outcome, result.outcome);
            errors++;
          end
          if (result.send_welcome !== exp.send_welcome) begin
            $error("send_welcome: expected %0d, actual %0d", exp.send_welcome,
                   result.send_welcome);
            errors++;
          end
          if (result.floor_value !== exp.floor_value) begin
            $error("floor_value: expected %0d, actual %0d", exp.floor_value,
                   result.floor_value);
            errors++;
          end
          if (result.slot !== exp.slot) begin
            $error("slot: expected %0d, actual %0d", exp.slot, result.slot);
            errors++;
          end
          if (result.disconnected_count !== exp.disconnected_count) begin
            $error("disconnected_count: expected %0d, actual %0d", exp.disconnected_count,
                   result.disconnected_count);
            errors++;
          end
        end
        outcome_hits[result.outcome]++;
        disc_total += result.disconnected_count;
        results_seen++;
        drain_gap = pick_gap(results_seen);
      end
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else if (!hold_done && results_seen >= 60) begin
        hold_done = 1;
        hold_left = HOLD_CYCLES;
        pop <= 1'b0;
      end else if (drain_gap > 0) begin
        drain_gap--;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    logic [ADDR_W-1:0] addr_a;
    addr_a = 48'h1234_5678_9ABC;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    check_config();
    set_config(TIMEOUT_W'(1000), 1'b1);

    // directed: empty table, first nodes, floor rules, sweeps, reconnect, bad kinds
    add_item(KIND_LOOKUP, '0, '0, '0, '0, '0, '0);
    add_item(KIND_TICK, '0, '0, '0, '0, '0, '0);
    add_item(KIND_DATA, addr_a, TIME_W'(5), 2'd3, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    add_item(KIND_REGISTER, '0, '0, '0, '0, '0, '0);
    add_item(KIND_REGISTER, '1, TIME_W'(10), '0, '0, '0, '0);
    add_item(KIND_REGISTER, addr_a, TIME_W'(20), '0, '0, '0, '0);
    add_item(KIND_DATA, '0, TIME_W'(30), 2'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    add_item(KIND_DATA, '1, TIME_W'(40), 2'd3, 16'h0001, 16'hFFFF, 16'h0007);
    add_item(KIND_DATA, addr_a, TIME_W'(50), 2'd1, 16'h0005, 16'hFFFF, 16'hFFFF);
    add_item(KIND_DATA, addr_a, TIME_W'(60), 2'd2, 16'h0003, 16'h0009, 16'hFFFF);
    add_item(KIND_DATA, addr_a, TIME_W'(70), 2'd3, 16'h0002, 16'h0002, 16'h0002);
    add_item(KIND_LOOKUP, '1, TIME_W'(80), '0, '0, '0, '0);
    add_item(KIND_LOOKUP, 48'h0000_0BAD_F00D, TIME_W'(90), '0, '0, '0, '0);
    add_item(KIND_TICK, '0, TIME_W'(500), '0, '0, '0, '0);
    add_item(KIND_TICK, '0, TIME_W'(1045), '0, '0, '0, '0);
    add_item(KIND_TICK, '0, TIME_W'(5), '0, '0, '0, '0);
    add_item(KIND_REGISTER, '0, TIME_W'(1100), '0, '0, '0, '0);
    add_item(KIND_DATA, '0, TIME_W'(1110), 2'd1, 16'h0000, 16'hFFFF, 16'hFFFF);
    for (int k = KIND_BAD_FIRST; k <= KIND_BAD_LAST; k++)
      add_item(KIND_W'(k), '1, '1, '1, '1, '1, '1);
    add_item(KIND_DATA, addr_a, '1, 2'd3, 16'h8000, 16'h7FFF, 16'h0100);
    add_item(KIND_TICK, '0, '0, '0, '0, '0, '0);
    wait_idle();
    reg_pool.push_back('0);
    reg_pool.push_back('1);
    reg_pool.push_back(addr_a);
    now_clock = TIME_W'(100000);

    set_config('0, 1'b0);
    gen_phase(PHASE_ITEMS);
    wait_idle();
    set_config('1, 1'b1);
    gen_phase(PHASE_ITEMS);
    wait_idle();
    set_config(TIMEOUT_W'($urandom_range(200, 3000)), 1'b1);
    gen_phase(PHASE_ITEMS);
    wait_idle();
    set_config(TIMEOUT_RESET, 1'b0);
    gen_phase(PHASE_ITEMS);
    wait_idle();
    set_config(TIMEOUT_W'({$urandom(), $urandom()}), 1'b1);
    gen_phase(PHASE_ITEMS);
    wait_idle();
    repeat (50) @(posedge clk);

    $display("Covered %0d requests under %0d register settings; table holds %0d of %0d nodes.",
             items_accepted, settings_written, nodes_used, SLOTS);
    $display("Outcomes: %0d new, %0d reconnected, %0d full, %0d acked, %0d sweeps, %0d timed out.",
             outcome_hits[OUT_NEW], outcome_hits[OUT_RECONNECTED], outcome_hits[OUT_FULL],
             outcome_hits[OUT_ACKED], outcome_hits[OUT_SWEEP], disc_total);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/nsr_pkg.sv
rtl/nsr_fifo.sv
rtl/nsr_front.sv
rtl/nsr_back.sv
rtl/node_session_registry_core.sv
tb/testbench.sv
